/* hdl/gni_pkg.sv */
// Shared types, constants and the weight table of the Gaussian neighborhood interpolator.
// Used by gni_ctrl, gni_dp and the top level; depends on nothing.
package gni_pkg;

  localparam int DEF_MAX_X        = 32;
  localparam int DEF_MAX_Y        = 32;
  localparam int DEF_MAX_Z        = 32;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int RESULT_LIMIT     = 16;

  // Exponent table: entry i holds exp(-i/32) as a 16-bit fraction.
  localparam int WEIGHT_DEPTH = 256;
  localparam int WIW          = $clog2(WEIGHT_DEPTH);
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

  // Divider geometry: a 56-bit dividend, a 24-bit divisor.
  localparam int DIV_NW  = 56;
  localparam int DIV_DW  = 24;
  localparam int DIST_W  = 20;
  localparam int DIV_CW  = $clog2(DIV_NW + 1);

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 12;
  localparam logic [CFG_IW-1:0] CFG_SIZE_X        = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SIZE_Y        = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SIZE_Z        = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_KERNEL_WIDTH  = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [15:0] weight_table_t [WEIGHT_DEPTH];

  function automatic weight_table_t build_weights();
    weight_table_t tbl;
    logic [63:0]   a;
    logic [63:0]   e;
    a = 64'd1 << 32;
    for (int i = 0; i < WEIGHT_DEPTH; i++) begin
      e = (a + 64'd32768) >> 16;
      tbl[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      a = (a * EXP_STEP_Q32) >> 32;
    end
    return tbl;
  endfunction

  localparam weight_table_t WEIGHTS = build_weights();

  typedef struct packed {
    logic idle;
    logic start;
    logic prep1;
    logic prep2;
    logic dist_calc;
    logic addr1;
    logic addr2;
    logic weight;
    logic mul;
    logic acc;
    logic div_final;
    logic emit;
  } gni_cmd_t;

  typedef struct packed {
    logic query_req;
    logic div_busy;
    logic last_chan;
    logic last_nb;
    logic out_free;
  } gni_sts_t;

endpackage

/* hdl/gni_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module gni_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/gni_ctrl.sv */
// Sequencer of the interpolator: walks neighbors, channels and the final divisions.
// Depends on gni_pkg for the command and status structs.
module gni_ctrl import gni_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gni_sts_t sts,
  output gni_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP1  = 4'd1;
  localparam logic [3:0] ST_PREP2  = 4'd2;
  localparam logic [3:0] ST_NDIST  = 4'd3;
  localparam logic [3:0] ST_NADDR1 = 4'd4;
  localparam logic [3:0] ST_NADDR2 = 4'd5;
  localparam logic [3:0] ST_NDIV   = 4'd6;
  localparam logic [3:0] ST_NWGT   = 4'd7;
  localparam logic [3:0] ST_CRD    = 4'd8;
  localparam logic [3:0] ST_CMUL   = 4'd9;
  localparam logic [3:0] ST_CACC   = 4'd10;
  localparam logic [3:0] ST_FLOAD  = 4'd11;
  localparam logic [3:0] ST_FDIV   = 4'd12;
  localparam logic [3:0] ST_FEMIT  = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.query_req) begin
          cmd.start = 1'b1;
          state_nxt = ST_PREP1;
        end
      end
      ST_PREP1: begin
        cmd.prep1 = 1'b1;
        state_nxt = ST_PREP2;
      end
      ST_PREP2: begin
        cmd.prep2 = 1'b1;
        state_nxt = ST_NDIST;
      end
      ST_NDIST: begin
        cmd.dist_calc = 1'b1;
        state_nxt     = ST_NADDR1;
      end
      ST_NADDR1: begin
        cmd.addr1 = 1'b1;
        state_nxt = ST_NADDR2;
      end
      ST_NADDR2: begin
        cmd.addr2 = 1'b1;
        state_nxt = ST_NDIV;
      end
      ST_NDIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_NWGT;
        end
      end
      ST_NWGT: begin
        cmd.weight = 1'b1;
        state_nxt  = ST_CRD;
      end
      ST_CRD: begin
        state_nxt = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CACC;
      end
      ST_CACC: begin
        cmd.acc = 1'b1;
        if (!sts.last_chan) begin
          state_nxt = ST_CRD;
        end else if (sts.last_nb) begin
          state_nxt = ST_FLOAD;
        end else begin
          state_nxt = ST_NDIST;
        end
      end
      ST_FLOAD: begin
        cmd.div_final = 1'b1;
        state_nxt     = ST_FDIV;
      end
      ST_FDIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_FEMIT;
        end
      end
      ST_FEMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_chan ? ST_IDLE : ST_FLOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/gni_dp.sv */
// Datapath of the interpolator: configuration registers, volume RAM, distance and
// weight logic, shared restoring divider, channel accumulators and the output register.
// Depends on gni_pkg and gni_ram.
module gni_dp import gni_pkg::*; #(
  parameter int MAX_X        = DEF_MAX_X,
  parameter int MAX_Y        = DEF_MAX_Y,
  parameter int MAX_Z        = DEF_MAX_Z,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gni_cmd_t              cmd,
  output gni_sts_t              sts,
  input  logic                  in_tvalid,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]            in_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [3:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_N = (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;
  localparam int CIW   = (ACC_N > 1) ? $clog2(ACC_N) : 1;

  function automatic logic [AW-1:0] clamp_size(logic [5:0] v, int hi);
    int vi;
    vi = int'(v);
    if (vi < 1) vi = 1;
    if (vi > hi) vi = hi;
    return AW'(vi);
  endfunction

  function automatic logic signed [12:0] nbr(logic [10:0] r, logic [1:0] o);
    return $signed({2'b00, r}) + $signed({11'b0, o}) - 13'sd1;
  endfunction

  function automatic logic [DIST_W-1:0] axis_sq(logic [10:0] r, logic [1:0] o,
                                                 logic [17:0] p);
    logic signed [20:0] d;
    logic signed [10:0] dt;
    logic signed [21:0] s;
    d  = $signed({nbr(r, o), 8'b0}) - $signed({3'b000, p});
    dt = d[10:0];
    s  = 22'(dt) * 22'(dt);
    return s[DIST_W-1:0];
  endfunction

  // Neighbor index clamped to the volume, converted to 0-based.
  function automatic logic [AW-1:0] clamp_index(logic signed [12:0] n, logic [AW-1:0] s);
    logic signed [31:0] ni;
    logic signed [31:0] si;
    ni = 32'(n);
    si = $signed(32'(s));
    if (ni < 1) return '0;
    if (ni > si) return AW'(si - 1);
    return AW'(ni - 1);
  endfunction

  // Configuration registers.
  logic [5:0]  size_x_r, size_y_r, size_z_r;
  logic [4:0]  chan_cnt_r;
  logic [11:0] kw_r;

  // Query state.
  logic [17:0]    px_r, py_r, pz_r;
  logic [10:0]    rx_r, ry_r, rz_r;
  logic [AW-1:0]  sx_r, sy_r, sz_r;
  logic [4:0]     nch_r;
  logic [11:0]    kwe_r;
  logic [AW-1:0]  stride1_r, stride_r;
  logic [1:0]     ox_r, oy_r, oz_r;
  logic [DIST_W-1:0] d2_r;
  logic [AW-1:0]  cx_r, cy_r, cz_r, t1_r, base_r, addr_r;
  logic [15:0]    w_r;
  logic [23:0]    wt_r;
  logic [4:0]     c_r;
  logic signed [32:0] prod_r;
  logic signed [47:0] acc_r [ACC_N];
  logic           neg_r;

  // Divider.
  logic [DIV_NW-1:0] div_num_r;
  logic [DIV_DW-1:0] div_rem_r, div_den_r;
  logic [DIV_CW-1:0] div_cnt_r;
  logic [DIV_DW:0]   rem_sh;
  logic              rem_ge;

  // Output register.
  logic              out_valid_r;
  logic [23:0]       out_data_r;
  logic [3:0]        out_chan_r;
  logic              out_last_r;

  // RAM port.
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [15:0]       ram_rdata;

  logic [18:0]       wr_addr;
  logic [2*AW-1:0]   mul_a, mul_b, mul_c, mul_d;
  logic [DIST_W-1:0] d2_nxt;
  logic [DIST_W-1:0] q_dist;
  logic [15:0]       w_nxt;
  logic signed [47:0] acc_sel;
  logic signed [55:0] num_s;
  logic [DIV_NW-1:0] mag;
  logic [DIV_NW-1:0] m;
  logic [23:0]       q_out;
  logic              last_chan;
  logic              last_nb;

  assign wr_addr  = in_tdata[18:0];
  assign ram_we   = cmd.idle && in_tvalid && (in_tuser[0] == OP_WRITE) &&
                    (32'(wr_addr) < DEPTH);
  assign ram_addr = ram_we ? AW'(wr_addr) : addr_r;

  gni_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[34:19]),
    .rdata (ram_rdata)
  );

  assign mul_a  = sx_r * sy_r;
  assign mul_b  = stride1_r * sz_r;
  assign mul_c  = sy_r * cz_r;
  assign mul_d  = sx_r * t1_r;
  assign d2_nxt = axis_sq(rx_r, ox_r, px_r) + axis_sq(ry_r, oy_r, py_r) +
                  axis_sq(rz_r, oz_r, pz_r);

  // Exponent index is the quotient over 8; past the table the weight is zero.
  assign q_dist = div_num_r[DIST_W-1:0];
  assign w_nxt  = (q_dist[DIST_W-1:WIW+3] == '0) ? WEIGHTS[q_dist[WIW+2:3]] : 16'd0;

  assign acc_sel = acc_r[c_r[CIW-1:0]];
  assign num_s   = {acc_sel, 8'b0};
  assign mag     = acc_sel[47] ? DIV_NW'(-num_s) : DIV_NW'(num_s);

  assign rem_sh = {div_rem_r, div_num_r[DIV_NW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den_r};

  assign last_chan = (c_r == nch_r - 5'd1);
  assign last_nb   = (ox_r == 2'd2) && (oy_r == 2'd2) && (oz_r == 2'd2);

  // Rounded magnitude, saturated to the 24-bit signed range.
  assign m = div_num_r;
  always_comb begin
    if (wt_r == '0) begin
      q_out = '0;
    end else if (neg_r) begin
      q_out = (m > DIV_NW'(8388608)) ? 24'h800000 : 24'(-m);
    end else begin
      q_out = (m > DIV_NW'(8388607)) ? 24'h7FFFFF : m[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= 6'd32;
      size_y_r    <= 6'd32;
      size_z_r    <= 6'd32;
      chan_cnt_r  <= 5'd16;
      kw_r        <= 12'd128;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE_X:        size_x_r   <= cfg_data[5:0];
          CFG_SIZE_Y:        size_y_r   <= cfg_data[5:0];
          CFG_SIZE_Z:        size_z_r   <= cfg_data[5:0];
          CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[4:0];
          CFG_KERNEL_WIDTH:  kw_r       <= cfg_data[11:0];
          default: ;
        endcase
      end

      if (cmd.addr1) begin
        div_cnt_r <= DIV_CW'(DIST_W);
      end else if (cmd.div_final) begin
        div_cnt_r <= DIV_CW'(DIV_NW);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DIV_CW'(1);
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r  <= in_tdata[52:35];
      py_r  <= in_tdata[70:53];
      pz_r  <= in_tdata[88:71];
      rx_r  <= 11'((19'(in_tdata[52:35]) + 19'd128) >> 8);
      ry_r  <= 11'((19'(in_tdata[70:53]) + 19'd128) >> 8);
      rz_r  <= 11'((19'(in_tdata[88:71]) + 19'd128) >> 8);
      sx_r  <= clamp_size(size_x_r, MAX_X);
      sy_r  <= clamp_size(size_y_r, MAX_Y);
      sz_r  <= clamp_size(size_z_r, MAX_Z);
      nch_r <= (chan_cnt_r == '0) ? 5'd1 :
               ((32'(chan_cnt_r) > ACC_N) ? 5'(ACC_N) : chan_cnt_r);
      kwe_r <= (kw_r == '0) ? 12'd1 : kw_r;
      ox_r  <= '0;
      oy_r  <= '0;
      oz_r  <= '0;
      c_r   <= '0;
      wt_r  <= '0;
      for (int i = 0; i < ACC_N; i++) begin
        acc_r[i] <= '0;
      end
    end
    if (cmd.prep1) stride1_r <= mul_a[AW-1:0];
    if (cmd.prep2) stride_r  <= mul_b[AW-1:0];
    if (cmd.dist_calc) begin
      d2_r <= d2_nxt;
      cx_r <= clamp_index(nbr(rx_r, ox_r), sx_r);
      cy_r <= clamp_index(nbr(ry_r, oy_r), sy_r);
      cz_r <= clamp_index(nbr(rz_r, oz_r), sz_r);
    end
    if (cmd.addr1) t1_r   <= cy_r + mul_c[AW-1:0];
    if (cmd.addr2) base_r <= cx_r + mul_d[AW-1:0];

    if (cmd.addr1) begin
      div_num_r <= {d2_r, {(DIV_NW-DIST_W){1'b0}}};
      div_den_r <= DIV_DW'(kwe_r);
      div_rem_r <= '0;
    end else if (cmd.div_final) begin
      div_num_r <= mag + DIV_NW'(wt_r >> 1);
      div_den_r <= wt_r;
      div_rem_r <= '0;
      neg_r     <= acc_sel[47];
    end else if (div_cnt_r != '0) begin
      div_num_r <= {div_num_r[DIV_NW-2:0], rem_ge};
      div_rem_r <= rem_ge ? DIV_DW'(rem_sh - {1'b0, div_den_r}) : rem_sh[DIV_DW-1:0];
    end

    if (cmd.weight) begin
      w_r    <= w_nxt;
      wt_r   <= wt_r + 24'(w_nxt);
      addr_r <= base_r;
      c_r    <= '0;
    end
    if (cmd.mul) prod_r <= $signed({1'b0, w_r}) * $signed(ram_rdata);
    if (cmd.acc) begin
      acc_r[c_r[CIW-1:0]] <= acc_r[c_r[CIW-1:0]] + 48'(prod_r);
      if (last_chan) begin
        c_r <= '0;
        if (oz_r != 2'd2) begin
          oz_r <= oz_r + 2'd1;
        end else begin
          oz_r <= '0;
          if (oy_r != 2'd2) begin
            oy_r <= oy_r + 2'd1;
          end else begin
            oy_r <= '0;
            ox_r <= ox_r + 2'd1;
          end
        end
      end else begin
        c_r    <= c_r + 5'd1;
        addr_r <= addr_r + stride_r;
      end
    end
    if (cmd.emit) begin
      out_data_r <= q_out;
      out_chan_r <= c_r[3:0];
      out_last_r <= last_chan;
      c_r        <= last_chan ? 5'd0 : c_r + 5'd1;
    end
  end

  assign sts.query_req = in_tvalid && (in_tuser[0] == OP_QUERY);
  assign sts.div_busy  = (div_cnt_r != '0);
  assign sts.last_chan = last_chan;
  assign sts.last_nb   = last_nb;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_chan_r;
  assign out_tlast  = out_last_r;

endmodule

/* hdl/gaussian_neighborhood_interpolator_unit.sv */
// Top level of the Gaussian 3x3x3 neighborhood interpolator.
// Depends on gni_pkg, gni_ctrl, gni_dp (which holds gni_ram).
//
//   channel | direction | payload
//   in_     | slave     | tuser: op; tdata: sample_address, sample_value, point_x/y/z
//   out_    | master    | tuser: channel_index; tdata: interpolated; tlast: last channel
//   cfg_    | write     | cfg_index selects the register, cfg_data is the value
//
// In a query each of the 27 neighbors runs a 20-step divide for its exponent and then
// passes read, multiply and accumulate states per channel on the single volume RAM
// port; each result runs a 56-step divide.
// rst_n is synchronous; the volume RAM keeps its contents through reset.
// in_tready is high only while no query is in progress; a stalled result holds the
// sequencer until out_tready frees the output register.
module gaussian_neighborhood_interpolator_unit import gni_pkg::*; #(
  parameter int MAX_X        = DEF_MAX_X,
  parameter int MAX_Y        = DEF_MAX_Y,
  parameter int MAX_Z        = DEF_MAX_Z,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [18:0] sample_address, [34:19] sample_value, [52:35] point_x,
  // [70:53] point_y, [88:71] point_z, [95:89] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] op
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [23:0] interpolated
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [3:0] channel_index
  output logic [3:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data
);

  gni_cmd_t cmd;
  gni_sts_t sts;

  assign in_tready = cmd.idle;

  gni_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  gni_dp #(
    .MAX_X        (MAX_X),
    .MAX_Y        (MAX_Y),
    .MAX_Z        (MAX_Z),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* bench/gaussian_neighborhood_interpolator_unit_test.sv */
// Self-checking bench for the Gaussian 3x3x3 neighborhood interpolator: loads volume
// samples, sends query points and checks each per-channel result against a predictor.
// Depends on gni_pkg and gaussian_neighborhood_interpolator_unit.
`timescale 1ns / 1ps

import gni_pkg::*;

class interp_scoreboard;
  typedef struct {
    bit [3:0]  chan;
    bit [23:0] value;
    bit        is_last;
  } chan_result_t;

  localparam int STORE_N = 524288;

  shortint      volume [STORE_N];
  bit           loaded [STORE_N];
  bit [15:0]    exp_weight [256];
  int unsigned  reg_sx, reg_sy, reg_sz, reg_chans, reg_kw;
  chan_result_t awaited [$];
  int           errors, checked, queries, writes;

  function new();
    bit [95:0] a;
    bit [95:0] e;
    a = 96'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      e = (a + 96'd32768) >> 16;
      exp_weight[i] = (e > 96'd65535) ? 16'hFFFF : e[15:0];
      a = (a * 96'd4162825044) >> 32;
    end
    reg_sx = 32; reg_sy = 32; reg_sz = 32; reg_chans = 16; reg_kw = 128;
  endfunction

  function void set_reg(logic [CFG_IW-1:0] idx, int unsigned val);
    case (idx)
      CFG_SIZE_X:        reg_sx    = val & 'h3F;
      CFG_SIZE_Y:        reg_sy    = val & 'h3F;
      CFG_SIZE_Z:        reg_sz    = val & 'h3F;
      CFG_CHANNEL_COUNT: reg_chans = val & 'h1F;
      CFG_KERNEL_WIDTH:  reg_kw    = val & 'hFFF;
      default: ;
    endcase
  endfunction

  function int lim(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Neighbor index n (1-based) clamped into the volume, returned 0-based.
  function int edge_clamp(longint n, int hi);
    if (n < 1) return 0;
    if (n > hi) return hi - 1;
    return int'(n - 1);
  endfunction

  function int unsigned sample_index(int cx, int cy, int cz, int c);
    return cx + lim(reg_sx, 1, 32) * (cy + lim(reg_sy, 1, 32) *
           (cz + lim(reg_sz, 1, 32) * c));
  endfunction

  // Store entries a query at this point reads that hold no sample yet.
  function void unloaded_reads(bit [17:0] px, bit [17:0] py, bit [17:0] pz,
                               ref int unsigned miss [$]);
    longint rx, ry, rz;
    int unsigned k;
    rx = (px + 128) >> 8; ry = (py + 128) >> 8; rz = (pz + 128) >> 8;
    for (int ox = -1; ox <= 1; ox++)
      for (int oy = -1; oy <= 1; oy++)
        for (int oz = -1; oz <= 1; oz++)
          for (int c = 0; c < lim(reg_chans, 1, 16); c++) begin
            k = sample_index(edge_clamp(rx + ox, lim(reg_sx, 1, 32)),
                             edge_clamp(ry + oy, lim(reg_sy, 1, 32)),
                             edge_clamp(rz + oz, lim(reg_sz, 1, 32)), c);
            if (!loaded[k]) miss.push_back(k);
          end
  endfunction

  function void note_input(bit op, bit [18:0] addr, bit [15:0] val,
                           bit [17:0] px, bit [17:0] py, bit [17:0] pz);
    longint       p [3];
    longint       r [3];
    longint       acc [16];
    longint       d2, num, wt;
    longint unsigned mag, m, wsum, widx;
    int           nch, kw, k;
    chan_result_t res;
    if (op == OP_WRITE) begin
      volume[addr] = val;
      loaded[addr] = 1'b1;
      writes++;
      return;
    end
    queries++;
    nch = lim(reg_chans, 1, 16);
    kw  = (reg_kw == 0) ? 1 : reg_kw;
    p[0] = px; p[1] = py; p[2] = pz;
    for (int a = 0; a < 3; a++) r[a] = (p[a] + 128) >> 8;
    foreach (acc[c]) acc[c] = 0;
    wsum = 0;
    for (int ox = -1; ox <= 1; ox++)
      for (int oy = -1; oy <= 1; oy++)
        for (int oz = -1; oz <= 1; oz++) begin
          d2 = ((r[0] + ox) * 256 - p[0]) ** 2 + ((r[1] + oy) * 256 - p[1]) ** 2 +
               ((r[2] + oz) * 256 - p[2]) ** 2;
          widx = (d2 / kw) >> 3;
          wt = (widx < 256) ? exp_weight[widx] : 0;
          for (int c = 0; c < nch; c++) begin
            k = sample_index(edge_clamp(r[0] + ox, lim(reg_sx, 1, 32)),
                             edge_clamp(r[1] + oy, lim(reg_sy, 1, 32)),
                             edge_clamp(r[2] + oz, lim(reg_sz, 1, 32)), c);
            acc[c] += wt * longint'(volume[k]);
          end
          wsum += wt;
        end
    for (int c = 0; c < nch; c++) begin
      num = 0;
      if (wsum != 0) begin
        mag = (acc[c] < 0) ? -acc[c] * 256 : acc[c] * 256;
        m = (mag + wsum / 2) / wsum;
        if (acc[c] < 0) num = (m > 8388608) ? -8388608 : -longint'(m);
        else num = (m > 8388607) ? 8388607 : longint'(m);
      end
      res.chan = 4'(c);
      res.value = num[23:0];
      res.is_last = (c + 1 == nch);
      awaited.push_back(res);
    end
  endfunction

  function void check_result(bit [3:0] chan, bit [23:0] value, bit is_last);
    chan_result_t want;
    checked++;
    if (awaited.size() == 0) begin
      $error("unexpected result: channel_index %0d interpolated %0d", chan,
             $signed(value));
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (chan != want.chan) begin
      $error("channel_index: expected %0d, got %0d", want.chan, chan);
      errors++;
    end
    if (value != want.value) begin
      $error("interpolated: expected %0d, got %0d", $signed(want.value), $signed(value));
      errors++;
    end
    if (is_last != want.is_last) begin
      $error("last_channel: expected %0d, got %0d", want.is_last, is_last);
      errors++;
    end
  endfunction
endclass

module gaussian_neighborhood_interpolator_unit_test;
  localparam longint CYCLE_LIMIT = 3000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [3:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IW-1:0]     cfg_index;
  logic [CFG_DW-1:0]     cfg_data;

  interp_scoreboard sb = new();
  bit      quiet;
  int      stall_left;
  int      settings;
  longint  cycles;

  gaussian_neighborhood_interpolator_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall bursts, none once the closing phase starts.
  always @(posedge clk) begin
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);

  task automatic send_item(bit op, bit [18:0] addr, bit [15:0] val,
                           bit [17:0] px, bit [17:0] py, bit [17:0] pz);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, pz, py, px, val, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, addr, val, px, py, pz);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Loads any sample the query would read that was never written, then queries.
  task automatic query_point(bit [17:0] px, bit [17:0] py, bit [17:0] pz);
    int unsigned miss [$];
    sb.unloaded_reads(px, py, pz, miss);
    foreach (miss[i])
      if (!sb.loaded[miss[i]])
        send_item(OP_WRITE, 19'(miss[i]), 16'($urandom), '0, '0, '0);
    send_item(OP_QUERY, 19'($urandom), 16'($urandom), px, py, pz);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(int sx, int sy, int sz, int nch, int kw);
    int unsigned vals [5];
    vals = '{sx, sy, sz, nch, kw};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_data  <= CFG_DW'(vals[i]);
      @(posedge clk);
      sb.set_reg(CFG_IW'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Mostly points in or just around the volume, now and then anywhere in the field range.
  function automatic bit [17:0] pick_coord(int unsigned size);
    if ($urandom_range(0, 6) == 0) return 18'($urandom);
    return 18'($urandom_range(0, (size + 1) * 256));
  endfunction

  task automatic random_phase(int items, bit pause_midway);
    for (int i = 0; i < items; i++) begin
      if (pause_midway && i == items / 2) begin
        in_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 3)
        send_item(OP_WRITE, 19'($urandom_range(0, 63)), 16'($urandom), 18'($urandom),
                  18'($urandom), 18'($urandom));
      else
        query_point(pick_coord(sb.lim(sb.reg_sx, 1, 32)), pick_coord(sb.lim(sb.reg_sy, 1, 32)),
                    pick_coord(sb.lim(sb.reg_sz, 1, 32)));
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: extreme samples at both ends of the store, read from the corners.
    send_item(OP_WRITE, 19'd0, 16'h8000, '0, '0, '0);
    send_item(OP_WRITE, 19'h7FFFF, 16'h7FFF, '0, '0, '0);
    query_point(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    query_point(18'd0, 18'd0, 18'd0);
    drain();

    // Narrowest kernel: a point halfway between voxels gets no weight at all.
    configure(3, 2, 2, 1, 1);
    query_point(18'd640, 18'd384, 18'd640);
    query_point(18'd512, 18'd512, 18'd512);
    send_item(OP_WRITE, 19'($urandom), 16'h7FFF, '0, '0, '0);
    drain();

    // Smallest volume with the widest kernel.
    configure(1, 1, 1, 1, 4095);
    query_point(18'd256, 18'd256, 18'd256);
    query_point(18'd300, 18'd1000, 18'd77);
    drain();

    // Register values outside their range are clamped; zero kernel acts as one.
    configure(0, 63, 1, 31, 0);
    query_point(18'd256, 18'h3FFFF, 18'd700);
    query_point(18'd200, 18'h3FF00, 18'd1400);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      configure($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                $urandom_range(1, 2),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4095) : $urandom_range(32, 1024));
      random_phase(5, ph == 1);
    end

    quiet = 1'b1;
    configure(3, 3, 2, 2, 128);
    random_phase(5, 1'b0);

    $display("Covered %0d queries and %0d sample writes over %0d register settings;",
             sb.queries, sb.writes, settings + 1);
    $display("%0d results were compared field by field.", sb.checked);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
